@@ rtl/core/multichannel_alpha_beta_filter_core_assert.svh @@
// ----------------------------------------------------------------------------
// Alpha-beta filter assertion macros
// Shared concurrent assertion forms for the filter core checkers.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ALPHA_BETA_FILTER_CORE_ASSERT_SVH
`define MULTICHANNEL_ALPHA_BETA_FILTER_CORE_ASSERT_SVH

// property checked outside reset
`define MABF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("alpha-beta filter assertion failed");

// property that also looks at reset itself
`define MABF_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("alpha-beta filter reset assertion failed");

`endif

@@ rtl/core/mabf_pkg.sv @@
// ----------------------------------------------------------------------------
// Alpha-beta filter package
// Widths, codes, transaction types and saturation helper of the filter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mabf_pkg;

  localparam int CHANNELS  = 16;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_IN_W = 10;
  localparam int OP_W      = 2;
  localparam int SAMPLE_W  = 16;
  localparam int ALPHA_W   = 17;
  localparam int VGAIN_W   = 24;
  localparam int DT_W      = 24;
  localparam int Q_W       = 40;
  localparam int FRAC_W    = 16;

  localparam int PIECE_W   = Q_W / 2;
  localparam int MUL_A_W   = VGAIN_W + 1;
  localparam int MUL_B_W   = PIECE_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = VGAIN_W + Q_W + 1;
  localparam int TERM_W    = ACC_W - FRAC_W;
  localparam int SUM_W     = TERM_W + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_W  = 32;
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_DELTA_T = 2'd0;
  localparam logic [DT_W-1:0]   DELTA_T_RESET = 24'd65536;

  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_COEF    = 2'd2;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] Q_MAX_EXT = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] Q_MIN_EXT = {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_RESTART,
    KIND_COEF
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ALPHA_W-1:0]         alpha;
    logic [VGAIN_W-1:0]         vgain;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_VLO,
    B_VHI,
    B_ALO,
    B_AHI,
    B_DLO,
    B_DHI,
    B_POS
  } back_state_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX_EXT) begin
      r = Q_MAX;
    end else if (v < Q_MIN_EXT) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/multichannel_alpha_beta_filter_core.sv @@
// ----------------------------------------------------------------------------
// Multichannel alpha-beta filter core
// Per-channel position/velocity tracker in Q24.16 with an APB delta_t register.
// ----------------------------------------------------------------------------
// Flow: a sample transaction goes from the queue through B_READ, the six
//   partial products of the shared 25x21 multiplier and B_POS, which loads
//   the output register and waits while the output stalls; no new transaction
//   is taken before then. Restart and gain writes complete in B_IDLE.
// Reset: delta_t returns to 1.0, all channels unstarted, gains read as zero,
//   queue and output empty; no clearing pass.
`timescale 1ns / 1ps

module multichannel_alpha_beta_filter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mabf_pkg::ADDR_W-1:0]          paddr,
  input  logic [mabf_pkg::APB_W-1:0]           pwdata,
  output logic [mabf_pkg::APB_W-1:0]           prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mabf_pkg::OP_W-1:0]            op,
  input  logic [mabf_pkg::CHAN_IN_W-1:0]       channel,
  input  logic signed [mabf_pkg::SAMPLE_W-1:0] sample,
  input  logic [mabf_pkg::ALPHA_W-1:0]         alpha_gain,
  input  logic [mabf_pkg::VGAIN_W-1:0]         velocity_gain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mabf_pkg::CHAN_IN_W-1:0]       out_channel,
  output logic signed [mabf_pkg::Q_W-1:0]      position_estimate,
  output logic signed [mabf_pkg::Q_W-1:0]      velocity_estimate
);

  logic [mabf_pkg::DT_W-1:0] delta_t;
  logic                      cmd_valid;
  logic                      cmd_ready;
  mabf_pkg::cmd_t            cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == mabf_pkg::ADDR_DELTA_T) ?
                  mabf_pkg::APB_W'(delta_t) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_t <= mabf_pkg::DELTA_T_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == mabf_pkg::ADDR_DELTA_T)) begin
      delta_t <= pwdata[mabf_pkg::DT_W-1:0];
    end
  end

  mabf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .channel       (channel),
    .sample        (sample),
    .alpha_gain    (alpha_gain),
    .velocity_gain (velocity_gain),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  mabf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .delta_t           (delta_t),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .position_estimate (position_estimate),
    .velocity_estimate (velocity_estimate)
  );

endmodule

@@ rtl/core/mabf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mabf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mabf_front.sv @@
// ----------------------------------------------------------------------------
// Alpha-beta filter front end
// Accepts transactions, drops unused ops and sample or gain writes to
// out-of-range channels, queues the rest for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mabf_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mabf_pkg::OP_W-1:0]            op,
  input  logic [mabf_pkg::CHAN_IN_W-1:0]       channel,
  input  logic signed [mabf_pkg::SAMPLE_W-1:0] sample,
  input  logic [mabf_pkg::ALPHA_W-1:0]         alpha_gain,
  input  logic [mabf_pkg::VGAIN_W-1:0]         velocity_gain,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output mabf_pkg::cmd_t                       cmd
);

  mabf_pkg::cmd_t                queue [mabf_pkg::QUEUE_DEPTH];
  logic [mabf_pkg::QP_W-1:0]     wr_ptr;
  logic [mabf_pkg::QP_W-1:0]     rd_ptr;
  logic [mabf_pkg::QC_W-1:0]     count;
  logic                          in_range;
  logic                          keep;
  mabf_pkg::kind_t               kind;
  mabf_pkg::cmd_t                entry;
  logic                          push;
  logic                          pop;

  assign in_range = ({1'b0, channel} < (mabf_pkg::CHAN_IN_W + 1)'(mabf_pkg::CHANNELS));

  always_comb begin
    unique case (op)
      mabf_pkg::OP_SAMPLE: begin
        keep = in_range;
        kind = mabf_pkg::KIND_SAMPLE;
      end
      mabf_pkg::OP_RESTART: begin
        keep = 1'b1;
        kind = mabf_pkg::KIND_RESTART;
      end
      mabf_pkg::OP_COEF: begin
        keep = in_range;
        kind = mabf_pkg::KIND_COEF;
      end
      default: begin
        keep = 1'b0;
        kind = mabf_pkg::KIND_SAMPLE;
      end
    endcase
  end

  always_comb begin
    entry.kind   = kind;
    entry.ch     = channel[mabf_pkg::CH_W-1:0];
    entry.sample = sample;
    entry.alpha  = alpha_gain;
    entry.vgain  = velocity_gain;
  end

  assign in_stall  = (count == mabf_pkg::QC_W'(mabf_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mabf_pkg::QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mabf_pkg::QP_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + mabf_pkg::QC_W'(1);
        2'b01:   count <= count - mabf_pkg::QC_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/mabf_back.sv @@
// ----------------------------------------------------------------------------
// Alpha-beta filter back end
// Executes queued transactions: restart, gain write and the per-channel
// update on one shared 25x21 multiplier, with an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mabf_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  mabf_pkg::cmd_t                       cmd,
  input  logic [mabf_pkg::DT_W-1:0]            delta_t,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mabf_pkg::CHAN_IN_W-1:0]       out_channel,
  output logic signed [mabf_pkg::Q_W-1:0]      position_estimate,
  output logic signed [mabf_pkg::Q_W-1:0]      velocity_estimate
);

  localparam int PV_W = 2 * mabf_pkg::Q_W;
  localparam int G_W  = mabf_pkg::ALPHA_W + mabf_pkg::VGAIN_W;

  mabf_pkg::back_state_t state;
  mabf_pkg::back_state_t state_next;
  mabf_pkg::cmd_t        cur;

  logic [mabf_pkg::CHANNELS-1:0] started;
  logic [mabf_pkg::CHANNELS-1:0] coef_ok;

  logic                      out_free;
  logic                      pv_we;
  logic                      gain_we;
  logic [mabf_pkg::CH_W-1:0] rd_addr;
  logic [PV_W-1:0]           pv_rdata;
  logic [G_W-1:0]            gain_rdata;

  logic signed [mabf_pkg::Q_W-1:0]  sq;
  logic signed [mabf_pkg::Q_W-1:0]  pos_rd;
  logic signed [mabf_pkg::Q_W-1:0]  vel_rd;
  logic signed [mabf_pkg::Q_W-1:0]  pos0_c;
  logic signed [mabf_pkg::Q_W-1:0]  vel0_c;
  logic signed [mabf_pkg::Q_W-1:0]  diff_c;
  logic [mabf_pkg::ALPHA_W-1:0]     alpha_c;
  logic [mabf_pkg::VGAIN_W-1:0]     vgain_c;

  logic signed [mabf_pkg::Q_W-1:0]  pos0;
  logic signed [mabf_pkg::Q_W-1:0]  vel0;
  logic signed [mabf_pkg::Q_W-1:0]  diff;
  logic [mabf_pkg::ALPHA_W-1:0]     alpha_r;
  logic [mabf_pkg::VGAIN_W-1:0]     vgain_r;
  logic signed [mabf_pkg::Q_W-1:0]  vel_new;
  logic signed [mabf_pkg::Q_W-1:0]  vel_new_c;
  logic signed [mabf_pkg::Q_W-1:0]  pos_new_c;

  logic [mabf_pkg::VGAIN_W-1:0]       mul_gain;
  logic signed [mabf_pkg::Q_W-1:0]    mul_src;
  logic                               mul_hi;
  logic signed [mabf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mabf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mabf_pkg::PROD_W-1:0]  prod;
  logic signed [mabf_pkg::ACC_W-1:0]   acc;
  logic signed [mabf_pkg::ACC_W-1:0]   sum_hi;
  logic signed [mabf_pkg::TERM_W-1:0]  term_c;
  logic signed [mabf_pkg::TERM_W-1:0]  vterm;
  logic signed [mabf_pkg::TERM_W-1:0]  aterm;
  logic signed [mabf_pkg::TERM_W-1:0]  dterm;

  mabf_ram #(.WIDTH(PV_W), .DEPTH(mabf_pkg::CHANNELS)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (cur.ch),
    .wdata ({pos_new_c, vel_new}),
    .raddr (rd_addr),
    .rdata (pv_rdata)
  );

  mabf_ram #(.WIDTH(G_W), .DEPTH(mabf_pkg::CHANNELS)) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (cmd.ch),
    .wdata ({cmd.alpha, cmd.vgain}),
    .raddr (rd_addr),
    .rdata (gain_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mabf_pkg::B_IDLE: begin
        if (cmd_valid && (cmd.kind == mabf_pkg::KIND_SAMPLE)) begin
          state_next = mabf_pkg::B_READ;
        end
      end
      mabf_pkg::B_READ: state_next = mabf_pkg::B_VLO;
      mabf_pkg::B_VLO:  state_next = mabf_pkg::B_VHI;
      mabf_pkg::B_VHI:  state_next = mabf_pkg::B_ALO;
      mabf_pkg::B_ALO:  state_next = mabf_pkg::B_AHI;
      mabf_pkg::B_AHI:  state_next = mabf_pkg::B_DLO;
      mabf_pkg::B_DLO:  state_next = mabf_pkg::B_DHI;
      mabf_pkg::B_DHI:  state_next = mabf_pkg::B_POS;
      mabf_pkg::B_POS: begin
        if (out_free) begin
          state_next = mabf_pkg::B_IDLE;
        end
      end
      default: state_next = mabf_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_ready = (state == mabf_pkg::B_IDLE);
    rd_addr   = (state == mabf_pkg::B_IDLE) ? cmd.ch : cur.ch;
    gain_we   = (state == mabf_pkg::B_IDLE) && cmd_valid &&
                (cmd.kind == mabf_pkg::KIND_COEF);
    pv_we     = (state == mabf_pkg::B_POS) && out_free;
    mul_hi    = (state == mabf_pkg::B_VHI) || (state == mabf_pkg::B_AHI) ||
                (state == mabf_pkg::B_DHI);
    unique case (state)
      mabf_pkg::B_VLO, mabf_pkg::B_VHI: begin
        mul_gain = vgain_r;
        mul_src  = diff;
      end
      mabf_pkg::B_ALO, mabf_pkg::B_AHI: begin
        mul_gain = mabf_pkg::VGAIN_W'(alpha_r);
        mul_src  = diff;
      end
      mabf_pkg::B_DLO, mabf_pkg::B_DHI: begin
        mul_gain = delta_t;
        mul_src  = vel_new;
      end
      default: begin
        mul_gain = '0;
        mul_src  = diff;
      end
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  // operand fetch
  always_comb begin
    sq      = mabf_pkg::Q_W'(cur.sample) <<< mabf_pkg::FRAC_W;
    pos_rd  = pv_rdata[PV_W-1:mabf_pkg::Q_W];
    vel_rd  = pv_rdata[mabf_pkg::Q_W-1:0];
    pos0_c  = started[cur.ch] ? pos_rd : sq;
    vel0_c  = started[cur.ch] ? vel_rd : '0;
    alpha_c = coef_ok[cur.ch] ? gain_rdata[G_W-1:mabf_pkg::VGAIN_W] : '0;
    vgain_c = coef_ok[cur.ch] ? gain_rdata[mabf_pkg::VGAIN_W-1:0] : '0;
    diff_c  = mabf_pkg::sat_q(mabf_pkg::SUM_W'(sq) - mabf_pkg::SUM_W'(pos0_c));
  end

  // gain times a 40-bit value in two 20-bit halves, round half up added on the low pass
  always_comb begin
    mul_a  = {1'b0, mul_gain};
    mul_b  = mul_hi ? {mul_src[mabf_pkg::Q_W-1], mul_src[mabf_pkg::Q_W-1:mabf_pkg::PIECE_W]}
                    : {1'b0, mul_src[mabf_pkg::PIECE_W-1:0]};
    prod   = mul_a * mul_b;
    sum_hi = acc + (mabf_pkg::ACC_W'(prod) <<< mabf_pkg::PIECE_W);
    term_c = sum_hi[mabf_pkg::ACC_W-1:mabf_pkg::FRAC_W];
  end

  assign vel_new_c = mabf_pkg::sat_q(mabf_pkg::SUM_W'(vel0) + mabf_pkg::SUM_W'(vterm));
  assign pos_new_c = mabf_pkg::sat_q(mabf_pkg::SUM_W'(pos0) + mabf_pkg::SUM_W'(aterm) +
                                     mabf_pkg::SUM_W'(dterm));

  always_ff @(posedge clk) begin
    if ((state == mabf_pkg::B_IDLE) && cmd_valid) begin
      cur <= cmd;
    end
    if (state == mabf_pkg::B_READ) begin
      pos0    <= pos0_c;
      vel0    <= vel0_c;
      diff    <= diff_c;
      alpha_r <= alpha_c;
      vgain_r <= vgain_c;
    end
    if (!mul_hi) begin
      acc <= mabf_pkg::ACC_W'(prod) + mabf_pkg::ROUND_HALF;
    end
    if (state == mabf_pkg::B_VHI) begin
      vterm <= term_c;
    end
    if (state == mabf_pkg::B_ALO) begin
      vel_new <= vel_new_c;
    end
    if (state == mabf_pkg::B_AHI) begin
      aterm <= term_c;
    end
    if (state == mabf_pkg::B_DHI) begin
      dterm <= term_c;
    end
    if (pv_we) begin
      out_channel       <= mabf_pkg::CHAN_IN_W'(cur.ch);
      position_estimate <= pos_new_c;
      velocity_estimate <= vel_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mabf_pkg::B_IDLE;
      started   <= '0;
      coef_ok   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == mabf_pkg::B_IDLE) && cmd_valid &&
          (cmd.kind == mabf_pkg::KIND_RESTART)) begin
        started <= '0;
      end else if (pv_we) begin
        started[cur.ch] <= 1'b1;
      end
      if (gain_we) begin
        coef_ok[cmd.ch] <= 1'b1;
      end
      if (pv_we) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/mabf_checker.sv @@
// ----------------------------------------------------------------------------
// Alpha-beta filter port checker
// Port-level assertions on the filter core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_alpha_beta_filter_core_assert.svh"

module mabf_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [mabf_pkg::ADDR_W-1:0]          paddr,
  input logic [mabf_pkg::APB_W-1:0]           pwdata,
  input logic [mabf_pkg::APB_W-1:0]           prdata,
  input logic                                 pready,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [mabf_pkg::CHAN_IN_W-1:0]       out_channel,
  input logic signed [mabf_pkg::Q_W-1:0]      position_estimate,
  input logic signed [mabf_pkg::Q_W-1:0]      velocity_estimate
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(position_estimate) && $stable(velocity_estimate);
  endproperty

  property p_delta_t_readback;
    (psel && penable && pwrite && pready && (paddr == mabf_pkg::ADDR_DELTA_T)) ##1
      (psel && !pwrite && (paddr == mabf_pkg::ADDR_DELTA_T)) |->
      (prdata[23:0] == $past(pwdata[23:0])) && (prdata[31:24] == 8'd0);
  endproperty

  `MABF_ASSERT(a_out_hold, p_out_hold)
  `MABF_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid)
  `MABF_ASSERT(a_channel_in_range, out_valid |-> ({1'b0, out_channel} < (mabf_pkg::CHAN_IN_W + 1)'(mabf_pkg::CHANNELS)))
  `MABF_ASSERT(a_delta_t_readback, p_delta_t_readback)

endmodule

bind multichannel_alpha_beta_filter_core mabf_checker u_mabf_checker (.*);

@@ test/tb_multichannel_alpha_beta_filter_core.sv @@
// ----------------------------------------------------------------------------
// Alpha-beta filter core testbench
// Drives sample, restart and gain-write transactions under several delta_t
// settings and flow-control patterns, predicts each channel's position and
// velocity update in Q24.16, and checks every estimate in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_alpha_beta_filter_core;
  import mabf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam logic signed [79:0] WIDE_MAX = 80'sd549755813887;
  localparam logic signed [79:0] WIDE_MIN = -80'sd549755813888;

  typedef struct {
    logic [CHAN_IN_W-1:0] ch;
    logic signed [Q_W-1:0] pos;
    logic signed [Q_W-1:0] vel;
  } estimate_t;

  class estimate_scoreboard;
    logic [DT_W-1:0] delta_t;
    logic signed [Q_W-1:0] pos_est [CHANNELS];
    logic signed [Q_W-1:0] vel_est [CHANNELS];
    bit tracking [CHANNELS];
    logic [ALPHA_W-1:0] alpha_tab [CHANNELS];
    logic [VGAIN_W-1:0] vgain_tab [CHANNELS];
    estimate_t expected_estimates [$];
    int errors;

    function new();
      delta_t = DELTA_T_RESET;
      restart_all();
      for (int i = 0; i < CHANNELS; i++) begin
        alpha_tab[i] = '0;
        vgain_tab[i] = '0;
      end
      errors = 0;
    endfunction

    function void restart_all();
      for (int i = 0; i < CHANNELS; i++) begin
        pos_est[i] = '0;
        vel_est[i] = '0;
        tracking[i] = 1'b0;
      end
    endfunction

    function logic signed [Q_W-1:0] clamp_q(logic signed [79:0] v);
      if (v > WIDE_MAX) return WIDE_MAX[Q_W-1:0];
      if (v < WIDE_MIN) return WIDE_MIN[Q_W-1:0];
      return v[Q_W-1:0];
    endfunction

    // gain * value, back to Q.16 with round half up
    function logic signed [79:0] scale_q16(logic [23:0] g, logic signed [79:0] v);
      logic signed [79:0] p;
      p = $signed({56'd0, g}) * v;
      return (p + 80'sd32768) >>> 16;
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction

    function void accept_item(logic [OP_W-1:0] op_code, logic [CHAN_IN_W-1:0] ch,
                              logic signed [SAMPLE_W-1:0] smp,
                              logic [ALPHA_W-1:0] al, logic [VGAIN_W-1:0] vg);
      int c;
      logic signed [79:0] meas;
      logic signed [Q_W-1:0] diff, vel, pos;
      estimate_t e;
      if (op_code == OP_RESTART) begin
        restart_all();
        return;
      end
      if (op_code == OP_UNUSED || {1'b0, ch} >= (CHAN_IN_W + 1)'(CHANNELS)) return;
      c = int'(ch);
      if (op_code == OP_COEF) begin
        alpha_tab[c] = al;
        vgain_tab[c] = vg;
        return;
      end
      meas = 80'(smp);
      meas = meas <<< 16;
      if (!tracking[c]) begin
        pos_est[c] = meas[Q_W-1:0];
        vel_est[c] = '0;
        tracking[c] = 1'b1;
      end
      diff = clamp_q(meas - 80'(pos_est[c]));
      vel = clamp_q(80'(vel_est[c]) + scale_q16(vgain_tab[c], 80'(diff)));
      pos = clamp_q(80'(pos_est[c]) + scale_q16(24'(alpha_tab[c]), 80'(diff)) +
                    scale_q16(delta_t, 80'(vel)));
      vel_est[c] = vel;
      pos_est[c] = pos;
      e.ch = ch;
      e.pos = pos;
      e.vel = vel;
      expected_estimates = {expected_estimates, e};
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_estimate(logic [CHAN_IN_W-1:0] ch, logic signed [Q_W-1:0] pos,
                        logic signed [Q_W-1:0] vel);
      estimate_t e;
      if (expected_estimates.size() == 0) begin
        report("unexpected estimate, channel", longint'(ch), -1);
        return;
      end
      e = expected_estimates.pop_front();
      if (ch !== e.ch) report("out_channel", longint'(ch), longint'(e.ch));
      if (pos !== e.pos) report("position_estimate", longint'(pos), longint'(e.pos));
      if (vel !== e.vel) report("velocity_estimate", longint'(vel), longint'(e.vel));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = '0;
  logic [CHAN_IN_W-1:0] channel = '0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [ALPHA_W-1:0] alpha_gain = '0;
  logic [VGAIN_W-1:0] velocity_gain = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAN_IN_W-1:0] out_channel;
  logic signed [Q_W-1:0] position_estimate;
  logic signed [Q_W-1:0] velocity_estimate;

  estimate_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  multichannel_alpha_beta_filter_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .channel(channel), .sample(sample),
    .alpha_gain(alpha_gain), .velocity_gain(velocity_gain),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .position_estimate(position_estimate), .velocity_estimate(velocity_estimate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // estimate receiver; a long hold-off is counted down here
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_estimate(out_channel, position_estimate, velocity_estimate);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(logic [OP_W-1:0] o, logic [CHAN_IN_W-1:0] ch,
                      logic signed [SAMPLE_W-1:0] smp, logic [ALPHA_W-1:0] al,
                      logic [VGAIN_W-1:0] vg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    channel <= ch;
    sample <= smp;
    alpha_gain <= al;
    velocity_gain <= vg;
    do @(posedge clk); while (in_stall);
    board.accept_item(o, ch, smp, al, vg);
  endtask

  task automatic send_random(output bit counted);
    int r;
    logic [OP_W-1:0] o;
    logic [CHAN_IN_W-1:0] ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic [ALPHA_W-1:0] al;
    logic [VGAIN_W-1:0] vg;
    r = $urandom_range(99);
    ch = CHAN_IN_W'($urandom_range(CHANNELS - 1));
    smp = SAMPLE_W'($urandom);
    al = ALPHA_W'($urandom);
    vg = VGAIN_W'($urandom);
    counted = 1'b1;
    if (r < 70) begin
      o = OP_SAMPLE;
      if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      else if ($urandom_range(2) == 0) smp = $signed(16'($urandom_range(400))) - 16'sd200;
    end else if (r < 84) begin
      o = OP_COEF;
      case ($urandom_range(4))
        0: al = ALPHA_W'($urandom);
        1: al = ALPHA_W'($urandom_range(2000));
        default: al = ALPHA_W'($urandom_range(65536));
      endcase
      case ($urandom_range(4))
        0, 1: vg = VGAIN_W'($urandom_range(8192));
        2: vg = VGAIN_W'($urandom_range(65536));
        default: vg = VGAIN_W'($urandom);
      endcase
    end else if (r < 87) begin
      o = OP_RESTART;
      ch = CHAN_IN_W'($urandom);
    end else if (r < 93) begin
      o = OP_UNUSED;
      ch = CHAN_IN_W'($urandom);
      counted = 1'b0;
    end else begin
      o = $urandom_range(1) ? OP_SAMPLE : OP_COEF;
      ch = CHAN_IN_W'($urandom_range(1023, CHANNELS));
      counted = 1'b0;
    end
    send(o, ch, smp, al, vg);
  endtask

  task automatic run_random(int n);
    int done;
    bit counted;
    done = 0;
    while (done < n) begin
      send_random(counted);
      if (counted) done++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delta_t(logic [DT_W-1:0] dt);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_DELTA_T;
    pwdata <= {{(APB_W-DT_W){1'b0}}, dt};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.delta_t = dt;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(logic [DT_W-1:0] dt, int idle, int stall, int n, int hold);
    write_delta_t(dt);
    send_idle_pct = idle;
    stall_pct = stall;
    if (hold > 0) hold_left = hold;
    run_random(n);
    wait_idle();
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(OP_COEF, 0, '0, 65536, 65536);
    send(OP_SAMPLE, 0, 16'sh7fff, '0, '0);
    send(OP_SAMPLE, 0, 16'sh8000, '0, '0);
    send(OP_SAMPLE, 0, 0, '0, '0);
    send(OP_COEF, 15, '0, 17'h1ffff, 24'hffffff);
    send(OP_SAMPLE, 15, 16'sh8000, '0, '0);
    send(OP_SAMPLE, 15, 16'sh7fff, '0, '0);
    send(OP_SAMPLE, 15, 16'sh7fff, '0, '0);
    send(OP_UNUSED, 0, '0, '0, '0);
    send(OP_SAMPLE, CHAN_IN_W'(CHANNELS), '0, '0, '0);
    send(OP_COEF, 1023, '0, '0, '0);
    send(OP_SAMPLE, 1, 0, '0, '0);
    send(OP_SAMPLE, 1, -1, '0, '0);
    send(OP_RESTART, 1023, '0, '0, '0);
    send(OP_SAMPLE, 15, 16'sh7fff, '0, '0);
    send(OP_SAMPLE, 15, 16'sh8000, '0, '0);
    send(OP_COEF, 0, '0, 0, 0);
    send(OP_SAMPLE, 0, 100, '0, '0);
    send(OP_SAMPLE, 0, -100, '0, '0);
    send(OP_COEF, 3, '0, 32768, 4096);
    send(OP_SAMPLE, 3, 1000, '0, '0);
    send(OP_SAMPLE, 3, 1200, '0, '0);
    send(OP_SAMPLE, 3, 1100, '0, '0);
    wait_idle();

    run_phase(24'd1, 0, 0, 180, 0);
    run_phase(24'hffffff, 74, 0, 180, 0);
    run_phase(24'd0, 0, 74, 180, 0);
    run_phase(DT_W'($urandom_range(200000, 1)), 16, 16, 180, 400);
    run_phase(24'd6554, 0, 0, 90, 300);
    run_phase(DELTA_T_RESET, $urandom_range(30), $urandom_range(30), 90, 0);

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
